// ===== design/lla_pkg.sv =====
package lla_pkg;

  // field widths
  localparam int SAMPLE_BITS    = 10;
  localparam int THRESH_BITS    = 10;
  localparam int CMP_BITS       = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  localparam int LEVEL_BITS     = 3;
  localparam int RETRY_BITS     = 8;
  localparam int ACTION_BITS    = 3;
  localparam int NUM_THRESH     = 5;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 10;

  typedef logic [LEVEL_BITS-1:0]  level_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [THRESH_BITS-1:0] thresh_t;
  typedef logic [RETRY_BITS-1:0]  retry_t;

  localparam level_t MAX_LEVEL = 3'd5;

  // button action codes
  typedef logic [ACTION_BITS-1:0] action_t;
  localparam action_t ACT_NONE     = 3'd0;
  localparam action_t ACT_POWER    = 3'd1;
  localparam action_t ACT_MODE     = 3'd2;
  localparam action_t ACT_INCREASE = 3'd3;
  localparam action_t ACT_DECREASE = 3'd4;

  // configuration register indexes
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_THRESH_ONE   = 3'd0;
  localparam cfg_index_t REG_THRESH_TWO   = 3'd1;
  localparam cfg_index_t REG_THRESH_THREE = 3'd2;
  localparam cfg_index_t REG_THRESH_FOUR  = 3'd3;
  localparam cfg_index_t REG_THRESH_FIVE  = 3'd4;
  localparam cfg_index_t REG_WANTED_COLD  = 3'd5;
  localparam cfg_index_t REG_WANTED_WARM  = 3'd6;
  localparam cfg_index_t REG_RETRY_LIMIT  = 3'd7;

  // register reset values, threshold one in the low slot
  localparam logic [NUM_THRESH-1:0][THRESH_BITS-1:0] THRESH_RESET =
    {10'd930, 10'd800, 10'd600, 10'd250, 10'd90};
  localparam level_t WANTED_RESET = 3'd0;
  localparam retry_t RETRY_LIMIT_RESET = 8'd10;

  // one result item
  typedef struct packed {
    action_t button_action;
    logic    fault;
    logic    aligned;
    level_t  cold_level;
    level_t  warm_level;
    level_t  target_cold_now;
    level_t  target_warm_now;
  } result_t;

endpackage

// ===== design/lla_if.sv =====
// measurement channel
interface lla_meas_if import lla_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    command;
  sample_t cold_sample;
  sample_t warm_sample;

  modport source(output valid, command, cold_sample, warm_sample, input ready);
  modport sink(input valid, command, cold_sample, warm_sample, output ready);
endinterface

// result channel
interface lla_result_if import lla_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t button_action;
  logic    fault;
  logic    aligned;
  level_t  cold_level;
  level_t  warm_level;
  level_t  target_cold_now;
  level_t  target_warm_now;

  modport source(output valid, button_action, fault, aligned, cold_level, warm_level,
                 target_cold_now, target_warm_now, input ready);
  modport sink(input valid, button_action, fault, aligned, cold_level, warm_level,
               target_cold_now, target_warm_now, output ready);
endinterface

// ===== design/lamp_level_alignment_controller.sv =====
// Lamp level alignment controller.
// The meas channel carries one cold and one warm sample per transfer, plus a
// command bit that starts a new alignment with that measurement. For every
// measurement transfer exactly one result transfer leaves on the res channel:
// the button press to make (if any), a fault flag, the aligned flag, the two
// quantized levels and the tracked target levels.
// A result is registered in the result register, or in the skid entry when
// that is stalled. One measurement per cycle is taken while the skid entry
// is empty; comparator chain and phase walk sit between input and result
// register. A result register plus one skid entry lets one more measurement
// in while a result waits; meas.ready drops only when both are full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the edge
// and are meant to happen only while the block is idle.
// Synchronous reset loads the default thresholds and retry limit, zero wanted
// and tracked levels, the power phase with a zero retry count, and empties
// the result register and skid entry.
module lamp_level_alignment_controller import lla_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  lla_meas_if.sink                  meas,
  lla_result_if.source              res
);

  typedef enum logic [2:0] {
    PH_POWER = 3'd0,
    PH_MODE  = 3'd1,
    PH_INC   = 3'd2,
    PH_DEC   = 3'd3,
    PH_IDLE  = 3'd4
  } phase_t;

  // configuration registers
  logic [NUM_THRESH-1:0][THRESH_BITS-1:0] thresh;
  level_t wanted_cold;
  level_t wanted_warm;
  retry_t retry_limit;

  // alignment state
  phase_t phase, phase_next;
  retry_t retry_count, retry_count_next;
  level_t tracked_cold, tracked_cold_next;
  level_t tracked_warm, tracked_warm_next;

  // output register and skid entry
  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  result_t result;

  logic   in_fire;
  logic   out_take;
  level_t cold_lvl;
  level_t warm_lvl;

  // first threshold that the sample is below gives the level
  function automatic level_t quantize(input sample_t s,
                                      input logic [NUM_THRESH-1:0][THRESH_BITS-1:0] th);
    level_t lvl;
    logic   found;
    lvl   = MAX_LEVEL;
    found = 1'b0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      if (!found && (CMP_BITS'(s) < CMP_BITS'(th[k]))) begin
        lvl   = LEVEL_BITS'(k);
        found = 1'b1;
      end
    end
    return lvl;
  endfunction

  assign in_fire  = meas.valid && meas.ready;
  assign out_take = out_valid && res.ready;
  assign meas.ready = !skid_valid;

  assign cold_lvl = quantize(meas.cold_sample, thresh);
  assign warm_lvl = quantize(meas.warm_sample, thresh);

  // phase walk for one measurement
  always_comb begin
    logic   target_bad;
    level_t tc;
    level_t tw;
    phase_t ph;
    retry_t rc;
    logic   done;
    logic   meas_off, target_off;
    logic   power_diff, mode_diff, level_diff, lower, higher;
    action_t act;
    logic   flt;

    target_bad = (wanted_cold > MAX_LEVEL) || (wanted_warm > MAX_LEVEL) ||
                 ((wanted_cold != '0) && (wanted_warm != '0) && (wanted_cold != wanted_warm));
    if (meas.command) begin
      tc = target_bad ? '0 : wanted_cold;
      tw = target_bad ? '0 : wanted_warm;
      ph = PH_POWER;
      rc = '0;
    end else begin
      tc = tracked_cold;
      tw = tracked_warm;
      ph = phase;
      rc = retry_count;
    end

    meas_off   = (cold_lvl == '0) && (warm_lvl == '0);
    target_off = (tc == '0) && (tw == '0);
    power_diff = meas_off != target_off;
    mode_diff  = ((cold_lvl == '0) != (tc == '0)) || ((warm_lvl == '0) != (tw == '0));
    level_diff = (cold_lvl != tc) || (warm_lvl != tw);
    lower      = (cold_lvl < tc) || (warm_lvl < tw);
    higher     = (cold_lvl > tc) || (warm_lvl > tw);

    tracked_cold_next = tc;
    tracked_warm_next = tw;
    act  = ACT_NONE;
    flt  = 1'b0;
    done = 1'b0;

    // a met phase hands over to the next one on the same measurement
    for (int i = 0; i < 6; i++) begin
      if (!done) begin
        unique case (ph)
          PH_POWER: begin
            if (power_diff) begin
              act  = ACT_POWER;
              done = 1'b1;
            end else begin
              ph = PH_MODE;
              rc = '0;
            end
          end
          PH_MODE: begin
            if (mode_diff) begin
              act  = ACT_MODE;
              done = 1'b1;
            end else if (level_diff) begin
              ph = PH_INC;
              rc = '0;
            end else begin
              ph = PH_IDLE;
            end
          end
          PH_INC: begin
            if (lower) begin
              act  = ACT_INCREASE;
              done = 1'b1;
            end else begin
              ph = PH_DEC;
              rc = '0;
            end
          end
          PH_DEC: begin
            if (higher) begin
              act  = ACT_DECREASE;
              done = 1'b1;
            end else if (level_diff) begin
              ph = PH_INC;
              rc = '0;
            end else begin
              ph = PH_IDLE;
            end
          end
          default: begin
            // idle: target follows the measured levels
            ph = PH_IDLE;
            if (level_diff) begin
              tracked_cold_next = cold_lvl;
              tracked_warm_next = warm_lvl;
            end
            done = 1'b1;
          end
        endcase
      end
    end

    // per-phase retry limit, fault restarts alignment
    if (act != ACT_NONE) begin
      if (rc >= retry_limit) begin
        flt = 1'b1;
        ph  = PH_POWER;
        rc  = '0;
      end else begin
        rc = rc + 1'b1;
      end
    end

    phase_next       = ph;
    retry_count_next = rc;

    result.button_action   = act;
    result.fault           = flt;
    result.aligned         = (ph == PH_IDLE);
    result.cold_level      = cold_lvl;
    result.warm_level      = warm_lvl;
    result.target_cold_now = tracked_cold_next;
    result.target_warm_now = tracked_warm_next;
  end

  // control state, configuration and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh       <= THRESH_RESET;
      wanted_cold  <= WANTED_RESET;
      wanted_warm  <= WANTED_RESET;
      retry_limit  <= RETRY_LIMIT_RESET;
      phase        <= PH_POWER;
      retry_count  <= '0;
      tracked_cold <= WANTED_RESET;
      tracked_warm <= WANTED_RESET;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESH_ONE, REG_THRESH_TWO, REG_THRESH_THREE,
          REG_THRESH_FOUR, REG_THRESH_FIVE: begin
            thresh[cfg_index] <= cfg_data[THRESH_BITS-1:0];
          end
          REG_WANTED_COLD: begin
            wanted_cold <= cfg_data[LEVEL_BITS-1:0];
          end
          REG_WANTED_WARM: begin
            wanted_warm <= cfg_data[LEVEL_BITS-1:0];
          end
          REG_RETRY_LIMIT: begin
            retry_limit <= cfg_data[RETRY_BITS-1:0];
          end
        endcase
      end

      if (in_fire) begin
        phase        <= phase_next;
        retry_count  <= retry_count_next;
        tracked_cold <= tracked_cold_next;
        tracked_warm <= tracked_warm_next;
      end

      if (out_take || !out_valid) begin
        out_valid  <= skid_valid || in_fire;
        skid_valid <= skid_valid && in_fire;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_fire) begin
          skid_data <= result;
        end
      end else if (in_fire) begin
        out_data <= result;
      end
    end else if (in_fire) begin
      skid_data <= result;
    end
  end

  assign res.valid           = out_valid;
  assign res.button_action   = out_data.button_action;
  assign res.fault           = out_data.fault;
  assign res.aligned         = out_data.aligned;
  assign res.cold_level      = out_data.cold_level;
  assign res.warm_level      = out_data.warm_level;
  assign res.target_cold_now = out_data.target_cold_now;
  assign res.target_warm_now = out_data.target_warm_now;

endmodule

// ===== design/lla_checker.sv =====
module lla_checker import lla_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    meas_ready,
  input logic    res_valid,
  input logic    res_ready,
  input action_t res_button_action,
  input logic    res_fault,
  input logic    res_aligned,
  input level_t  res_cold_level,
  input level_t  res_warm_level,
  input level_t  res_target_cold_now,
  input level_t  res_target_warm_now
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_button_action) &&
      $stable(res_fault) && $stable(res_aligned) && $stable(res_target_cold_now) &&
      $stable(res_target_warm_now))
    else $error("stalled result changed");

  // a fault always comes with a press and never with alignment
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_fault |-> (res_button_action != ACT_NONE) && !res_aligned)
    else $error("fault without press");

  // aligned means no press and levels equal the target
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_aligned |-> (res_button_action == ACT_NONE) &&
      (res_cold_level == res_target_cold_now) && (res_warm_level == res_target_warm_now))
    else $error("aligned with level mismatch");

  // input backpressure only while a result waits
  assert property (@(posedge clk) disable iff (rst)
    !meas_ready |-> res_valid)
    else $error("input stalled with no pending result");

  // tracked target stays within the level range
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_target_cold_now <= MAX_LEVEL) && (res_target_warm_now <= MAX_LEVEL))
    else $error("target level out of range");

endmodule

bind lamp_level_alignment_controller lla_checker u_lla_checker (
  .clk                 (clk),
  .rst                 (rst),
  .meas_ready          (meas.ready),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .res_button_action   (res.button_action),
  .res_fault           (res.fault),
  .res_aligned         (res.aligned),
  .res_cold_level      (res.cold_level),
  .res_warm_level      (res.warm_level),
  .res_target_cold_now (res.target_cold_now),
  .res_target_warm_now (res.target_warm_now)
);

// ===== verif/lamp_level_alignment_controller_tb.sv =====
module lamp_level_alignment_controller_tb;
  import lla_pkg::*;

  // alignment phases of the controller
  typedef enum logic [2:0] {
    ALIGN_POWER = 3'd0,
    ALIGN_MODE  = 3'd1,
    ALIGN_INC   = 3'd2,
    ALIGN_DEC   = 3'd3,
    ALIGN_IDLE  = 3'd4
  } align_phase_t;

  localparam int NUM_SETTINGS   = 8;
  localparam int ITEMS_PER_SET  = 180;
  localparam int QUIET_LIMIT    = 2000;

  // predicts each result and holds the results still due from the block
  class lamp_alignment_scoreboard;
    thresh_t      thresholds [NUM_THRESH];
    level_t       wanted_cold;
    level_t       wanted_warm;
    retry_t       retry_limit;
    align_phase_t phase;
    retry_t       retry_count;
    level_t       tracked_cold;
    level_t       tracked_warm;
    result_t      expected_results [$];
    int           mismatches;
    int           results_checked;
    int           press_count [5];
    int           fault_count;
    int           aligned_count;

    function new();
      for (int k = 0; k < NUM_THRESH; k++) thresholds[k] = THRESH_RESET[k];
      wanted_cold = WANTED_RESET;
      wanted_warm = WANTED_RESET;
      retry_limit = RETRY_LIMIT_RESET;
      phase = ALIGN_POWER;
      retry_count = '0;
      tracked_cold = WANTED_RESET;
      tracked_warm = WANTED_RESET;
      mismatches = 0;
      results_checked = 0;
      fault_count = 0;
      aligned_count = 0;
      for (int k = 0; k < 5; k++) press_count[k] = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx <= REG_THRESH_FIVE) thresholds[idx] = data[THRESH_BITS-1:0];
      else if (idx == REG_WANTED_COLD) wanted_cold = data[LEVEL_BITS-1:0];
      else if (idx == REG_WANTED_WARM) wanted_warm = data[LEVEL_BITS-1:0];
      else if (idx == REG_RETRY_LIMIT) retry_limit = data[RETRY_BITS-1:0];
    endfunction

    // first threshold the sample is below decides the level
    function level_t level_of(sample_t s);
      for (int k = 0; k < NUM_THRESH; k++) begin
        if (s < thresholds[k]) return level_t'(k);
      end
      return MAX_LEVEL;
    endfunction

    function void note_measurement(logic start, sample_t cold_s, sample_t warm_s);
      level_t  c, w, tc, tw;
      action_t act;
      logic    flt;
      bit      done, m_off, t_off, power_diff, mode_diff, level_diff, below, above;
      result_t want;
      c = level_of(cold_s);
      w = level_of(warm_s);
      act = ACT_NONE;
      flt = 1'b0;
      done = 1'b0;
      // start loads the target, cleared when out of range or mismatched
      if (start) begin
        tc = wanted_cold;
        tw = wanted_warm;
        if (tc > MAX_LEVEL || tw > MAX_LEVEL || (tc != 0 && tw != 0 && tc != tw)) begin
          tc = '0;
          tw = '0;
        end
        tracked_cold = tc;
        tracked_warm = tw;
        phase = ALIGN_POWER;
        retry_count = '0;
      end
      // walk the phase chain until a press is asked or idle is reached
      for (int i = 0; i < 6 && !done; i++) begin
        m_off = (c == 0 && w == 0);
        t_off = (tracked_cold == 0 && tracked_warm == 0);
        power_diff = (m_off != t_off);
        mode_diff = ((c == 0) != (tracked_cold == 0)) || ((w == 0) != (tracked_warm == 0));
        level_diff = (c != tracked_cold) || (w != tracked_warm);
        below = (c < tracked_cold) || (w < tracked_warm);
        above = (c > tracked_cold) || (w > tracked_warm);
        case (phase)
          ALIGN_POWER: begin
            if (power_diff) begin
              act = ACT_POWER;
              done = 1'b1;
            end else begin
              phase = ALIGN_MODE;
              retry_count = '0;
            end
          end
          ALIGN_MODE: begin
            if (mode_diff) begin
              act = ACT_MODE;
              done = 1'b1;
            end else if (level_diff) begin
              phase = ALIGN_INC;
              retry_count = '0;
            end else begin
              phase = ALIGN_IDLE;
            end
          end
          ALIGN_INC: begin
            if (below) begin
              act = ACT_INCREASE;
              done = 1'b1;
            end else begin
              phase = ALIGN_DEC;
              retry_count = '0;
            end
          end
          ALIGN_DEC: begin
            if (above) begin
              act = ACT_DECREASE;
              done = 1'b1;
            end else if (level_diff) begin
              phase = ALIGN_INC;
              retry_count = '0;
            end else begin
              phase = ALIGN_IDLE;
            end
          end
          default: begin
            // idle: target follows what is measured
            phase = ALIGN_IDLE;
            if (level_diff) begin
              tracked_cold = c;
              tracked_warm = w;
            end
            done = 1'b1;
          end
        endcase
      end
      // retry accounting, fault restarts at power
      if (act != ACT_NONE) begin
        if (retry_count >= retry_limit) begin
          flt = 1'b1;
          phase = ALIGN_POWER;
          retry_count = '0;
        end else begin
          retry_count++;
        end
      end
      want.button_action = act;
      want.fault = flt;
      want.aligned = (phase == ALIGN_IDLE);
      want.cold_level = c;
      want.warm_level = w;
      want.target_cold_now = tracked_cold;
      want.target_warm_now = tracked_warm;
      press_count[act]++;
      fault_count += flt;
      aligned_count += want.aligned;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string field, int want, int seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      compare_field("button_action", want.button_action, got.button_action);
      compare_field("fault", want.fault, got.fault);
      compare_field("aligned", want.aligned, got.aligned);
      compare_field("cold_level", want.cold_level, got.cold_level);
      compare_field("warm_level", want.warm_level, got.warm_level);
      compare_field("target_cold_now", want.target_cold_now, got.target_cold_now);
      compare_field("target_warm_now", want.target_warm_now, got.target_warm_now);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  lla_meas_if   meas ();
  lla_result_if res ();

  lamp_level_alignment_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .meas      (meas),
    .res       (res)
  );

  lamp_alignment_scoreboard sb = new();

  bit      no_idle = 1'b0;
  bit      want_long_hold = 1'b0;
  int      items_sent = 0;
  level_t  lamp_cold = '0;
  level_t  lamp_warm = '0;
  thresh_t thresh_plan [NUM_THRESH];

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // random sample that lands on the wanted level under the current thresholds
  function automatic sample_t sample_for_level(level_t lvl);
    sample_t s;
    for (int k = 0; k < 40; k++) begin
      s = sample_t'($urandom);
      if (sb.level_of(s) == lvl) return s;
    end
    return s;
  endfunction

  function automatic level_t step_toward(level_t cur, level_t goal);
    if (cur < goal) return cur + 1'b1;
    if (cur > goal) return cur - 1'b1;
    return cur;
  endfunction

  // one measurement transfer, with a random gap in front
  task automatic send_item(logic start, sample_t cold_s, sample_t warm_s);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap > 0) begin
      meas.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas.valid       <= 1'b1;
    meas.command     <= start;
    meas.cold_sample <= cold_s;
    meas.warm_sample <= warm_s;
    do @(posedge clk); while (!meas.ready);
    sb.note_measurement(start, cold_s, warm_s);
    items_sent++;
  endtask

  // lamp that mostly moves toward the target, with some jumps and noise
  task automatic send_random_item();
    int   pick;
    logic start;
    pick = $urandom_range(0, 99);
    start = ($urandom_range(0, 99) < 4);
    if (pick < 12) begin
      send_item(start, sample_t'($urandom), sample_t'($urandom));
    end else begin
      if (pick < 25) begin
        lamp_cold = level_t'($urandom_range(0, MAX_LEVEL));
        lamp_warm = level_t'($urandom_range(0, MAX_LEVEL));
      end else if (pick < 92) begin
        lamp_cold = step_toward(lamp_cold, sb.tracked_cold);
        lamp_warm = step_toward(lamp_warm, sb.tracked_warm);
      end
      send_item(start, sample_for_level(lamp_cold), sample_for_level(lamp_warm));
    end
  endtask

  task automatic wait_for_results();
    meas.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // writes every register; only called while the block is idle
  task automatic program_settings(level_t cold_goal, level_t warm_goal, retry_t limit);
    logic [CFG_DATA_BITS-1:0] value [8];
    for (int k = 0; k < NUM_THRESH; k++) value[k] = thresh_plan[k];
    value[REG_WANTED_COLD] = CFG_DATA_BITS'(cold_goal);
    value[REG_WANTED_WARM] = CFG_DATA_BITS'(warm_goal);
    value[REG_RETRY_LIMIT] = CFG_DATA_BITS'(limit);
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(k);
      cfg_data  <= value[k];
      @(posedge clk);
      sb.write_register(cfg_index_t'(k), value[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(thresh_t a, thresh_t b, thresh_t c, thresh_t d, thresh_t e);
    thresh_plan[0] = a;
    thresh_plan[1] = b;
    thresh_plan[2] = c;
    thresh_plan[3] = d;
    thresh_plan[4] = e;
  endtask

  // result side: checks every transfer and stalls at random
  initial begin
    int      stall_left;
    result_t got;
    stall_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res.valid && res.ready) begin
          got.button_action   = res.button_action;
          got.fault           = res.fault;
          got.aligned         = res.aligned;
          got.cold_level      = res.cold_level;
          got.warm_level      = res.warm_level;
          got.target_cold_now = res.target_cold_now;
          got.target_warm_now = res.target_warm_now;
          sb.check_result(got);
        end
        if (want_long_hold) begin
          want_long_hold = 1'b0;
          stall_left = $urandom_range(40, 80);
        end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 25) begin
          stall_left = gap_length();
        end
        if (stall_left > 0) begin
          res.ready <= 1'b0;
          stall_left--;
        end else begin
          res.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (meas.valid && meas.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("lamp_level_alignment_controller_tb: done, errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    retry_t limit;
    level_t goal_c, goal_w;
    thresh_t t;
    int step;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    meas.valid       <= 1'b0;
    meas.command     <= 1'b0;
    meas.cold_sample <= '0;
    meas.warm_sample <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      // block must be drained before registers change
      wait_for_results();
      repeat (2) @(posedge clk);
      case (ph)
        0: begin
          set_thresholds(10'd90, 10'd250, 10'd600, 10'd800, 10'd930);
          goal_c = 3'd3;
          goal_w = 3'd3;
          limit = 8'd2;
        end
        1: begin
          set_thresholds(10'd90, 10'd250, 10'd600, 10'd800, 10'd930);
          goal_c = 3'd5;
          goal_w = 3'd0;
          limit = 8'd255;
        end
        2: begin
          set_thresholds(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
          goal_c = 3'd7;
          goal_w = 3'd2;
          limit = 8'd0;
        end
        3: begin
          set_thresholds(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
          goal_c = 3'd1;
          goal_w = 3'd1;
          limit = 8'd1;
        end
        4: begin
          set_thresholds(10'd700, 10'd100, 10'd1023, 10'd0, 10'd500);
          goal_c = 3'd4;
          goal_w = 3'd5;
          limit = 8'd10;
        end
        5: begin
          set_thresholds(10'd512, 10'd512, 10'd512, 10'd512, 10'd512);
          goal_c = 3'd0;
          goal_w = 3'd6;
          limit = 8'd3;
        end
        6: begin
          set_thresholds(thresh_t'($urandom), thresh_t'($urandom), thresh_t'($urandom),
                         thresh_t'($urandom), thresh_t'($urandom));
          goal_c = level_t'($urandom);
          goal_w = level_t'($urandom);
          limit = retry_t'($urandom_range(0, 15));
        end
        default: begin
          // ascending random thresholds
          t = '0;
          for (int k = 0; k < NUM_THRESH; k++) begin
            step = $urandom_range(0, 250);
            t = (int'(t) + step > 1023) ? 10'd1023 : thresh_t'(int'(t) + step);
            thresh_plan[k] = t;
          end
          goal_c = level_t'($urandom_range(0, MAX_LEVEL));
          goal_w = ($urandom_range(0, 1) == 0) ? goal_c : level_t'(0);
          limit = retry_t'($urandom);
        end
      endcase
      program_settings(goal_c, goal_w, limit);
      no_idle = (ph == 3 || ph == 6);

      // directed opening: threshold edges, every press, fault, start while busy
      if (ph == 0) begin
        send_item(1'b0, 10'd0, 10'd0);
        send_item(1'b0, 10'd1023, 10'd1023);
        send_item(1'b1, 10'd0, 10'd0);
        send_item(1'b0, 10'd89, 10'd90);
        send_item(1'b0, 10'd250, 10'd249);
        send_item(1'b1, 10'd600, 10'd599);
        send_item(1'b0, 10'd599, 10'd599);
        send_item(1'b0, 10'd250, 10'd250);
        send_item(1'b0, 10'd800, 10'd930);
        send_item(1'b0, 10'd600, 10'd600);
        send_item(1'b0, 10'd929, 10'd930);
        send_item(1'b0, 10'd1023, 10'd0);
        send_item(1'b1, 10'd799, 10'd800);
      end

      // random part, with a long receiver hold or a full drain midway
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (n == ITEMS_PER_SET / 2) begin
          if (ph % 2 == 1) want_long_hold = 1'b1;
          else wait_for_results();
        end
        send_random_item();
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    $display("run covered %0d measurements over %0d register settings, %0d results checked",
             items_sent, NUM_SETTINGS, sb.results_checked);
    $display("presses power %0d mode %0d increase %0d decrease %0d, faults %0d, aligned %0d",
             sb.press_count[ACT_POWER], sb.press_count[ACT_MODE],
             sb.press_count[ACT_INCREASE], sb.press_count[ACT_DECREASE],
             sb.fault_count, sb.aligned_count);
    if (sb.mismatches == 0) begin
      $display("lamp_level_alignment_controller_tb: done, clean");
    end else begin
      $display("lamp_level_alignment_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
